@@ rtl/api_fd_pkg.sv @@
package api_fd_pkg;

    // Payload store geometry
    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Frame constants
    localparam logic [7:0] DELIM          = 8'h7E;
    localparam logic [7:0] SUM_GOOD       = 8'hFF;
    localparam logic [8:0] MIN_FRAME      = 9'd10;
    localparam logic [8:0] PAYLOAD_START  = 9'd8;
    localparam logic [8:0] LEN_POS        = 9'd2;
    localparam logic [8:0] API_POS        = 9'd3;
    localparam logic [8:0] BODY_OVERHEAD  = 9'd4;
    localparam logic [8:0] PAYLOAD_OFFSET = 9'd9;
    localparam logic [7:0] API_ID_RESET   = 8'h81;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Frame status codes
    localparam logic [2:0] STAT_NONE     = 3'd0;
    localparam logic [2:0] STAT_ACCEPT   = 3'd1;
    localparam logic [2:0] STAT_OVERLONG = 3'd2;
    localparam logic [2:0] STAT_BAD_SUM  = 3'd3;
    localparam logic [2:0] STAT_WRONG_ID = 3'd4;

    // Register addresses (word index)
    localparam logic REG_API_ID = 1'b0;

    // Classified item as it waits between front and back
    typedef struct packed {
        logic       op;
        logic       delim;
        logic [7:0] data;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

@@ rtl/api_fd_front.sv @@
module api_fd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic                 s_axis_tuser,   // [0] op
    output api_fd_pkg::head_t    head,
    input  logic                 head_take
);

    localparam int QDEPTH = 2;

    api_fd_pkg::item_t q_data_reg [QDEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push_en;
    logic              pop_en;
    api_fd_pkg::item_t item_in;

    // Classify incoming transfer
    always_comb
    begin
        item_in.op    = s_axis_tuser;
        item_in.data  = s_axis_tdata;
        item_in.delim = (s_axis_tuser == api_fd_pkg::OP_PUSH) &&
                        (s_axis_tdata == api_fd_pkg::DELIM);
    end

    assign s_axis_tready = (count_reg != 2'(QDEPTH));
    assign push_en       = s_axis_tvalid && s_axis_tready;
    assign pop_en        = head_take && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_data_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push_en) - 2'(pop_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload of accepted transfer
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_data_reg[wr_ptr_reg] <= item_in;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("queue occupancy out of range");
    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg <= 2'd1))
        else $error("queue grew by more than one from empty");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");
`endif

endmodule

@@ rtl/api_fd_back.sv @@
module api_fd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  api_fd_pkg::head_t  head,
    output logic               head_take,
    input  logic [7:0]         expected_api_id,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata,  // [7:0] read_byte, [15:8] bytes_available,
                                              // [18:16] frame_status, [23:19] zero
    output logic               m_axis_tuser   // [0] read_valid
);

    logic [7:0] payload_mem [api_fd_pkg::STORE_DEPTH];

    logic       hunting_reg,   hunting_next;
    logic [8:0] count_reg,     count_next;
    logic [7:0] length_reg,    length_next;
    logic [7:0] api_reg,       api_next;
    logic [7:0] sum_reg,       sum_next;
    logic [7:0] ridx_reg,      ridx_next;
    logic [7:0] end_reg,       end_next;
    logic       ready_reg,     ready_next;

    logic       out_valid_reg, out_valid_next;
    logic       rvalid_reg,    rvalid_next;
    logic [7:0] avail_reg,     avail_next;
    logic [2:0] status_reg,    status_next;
    logic [7:0] rd_data_reg;

    logic       exec;
    logic       mem_we;
    logic       mem_re;
    logic [api_fd_pkg::STORE_AW-1:0] mem_waddr;
    logic [8:0] count_inc;
    logic [8:0] body;
    logic [7:0] ridx_inc;
    logic [7:0] b;

    assign exec      = head.valid && (!out_valid_reg || m_axis_tready);
    assign head_take = exec;
    assign b         = head.item.data;
    assign count_inc = count_reg + 9'd1;
    assign body      = count_inc - api_fd_pkg::BODY_OVERHEAD;
    assign ridx_inc  = ridx_reg + 8'd1;
    assign mem_waddr = api_fd_pkg::STORE_AW'(count_reg - api_fd_pkg::PAYLOAD_START);

    // Execute one item: pop, delimiter hunt, or frame collection
    always_comb
    begin
        hunting_next = hunting_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        api_next     = api_reg;
        sum_next     = sum_reg;
        ridx_next    = ridx_reg;
        end_next     = end_reg;
        ready_next   = ready_reg;
        rvalid_next  = 1'b0;
        status_next  = api_fd_pkg::STAT_NONE;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        if (exec)
        begin
            if (head.item.op == api_fd_pkg::OP_POP)
            begin
                if (ready_reg)
                begin
                    rvalid_next = 1'b1;
                    mem_re      = 1'b1;
                    if (ridx_inc == end_reg)
                    begin
                        ready_next = 1'b0;
                        ridx_next  = 8'd0;
                    end
                    else
                    begin
                        ridx_next = ridx_inc;
                    end
                end
            end
            else if (hunting_reg)
            begin
                if (head.item.delim)
                begin
                    hunting_next = 1'b0;
                    count_next   = 9'd1;
                    sum_next     = 8'd0;
                    ridx_next    = 8'd0;
                    end_next     = 8'd0;
                    ready_next   = 1'b0;
                end
            end
            else
            begin
                if (count_reg == api_fd_pkg::LEN_POS)
                    length_next = b;
                if (count_reg == api_fd_pkg::API_POS)
                    api_next = b;
                if (count_reg >= api_fd_pkg::API_POS)
                    sum_next = sum_reg + b;
                if (count_reg >= api_fd_pkg::PAYLOAD_START)
                    mem_we = 1'b1;
                count_next = count_inc;
                // Check frame once it reaches minimum size
                if (count_inc >= api_fd_pkg::MIN_FRAME)
                begin
                    if (body > {1'b0, length_next})
                    begin
                        hunting_next = 1'b1;
                        status_next  = api_fd_pkg::STAT_OVERLONG;
                    end
                    else if (body == {1'b0, length_next})
                    begin
                        if (sum_next != api_fd_pkg::SUM_GOOD)
                        begin
                            status_next = api_fd_pkg::STAT_BAD_SUM;
                        end
                        else if (api_next != expected_api_id)
                        begin
                            status_next = api_fd_pkg::STAT_WRONG_ID;
                        end
                        else
                        begin
                            hunting_next = 1'b1;
                            end_next     = 8'(count_inc - api_fd_pkg::PAYLOAD_OFFSET);
                            ridx_next    = 8'd0;
                            ready_next   = 1'b1;
                            status_next  = api_fd_pkg::STAT_ACCEPT;
                        end
                    end
                end
            end
        end

        avail_next     = ready_next ? (end_next - ridx_next) : 8'd0;
        out_valid_next = exec ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // Update frame state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg   <= 1'b1;
            count_reg     <= 9'd0;
            length_reg    <= 8'd0;
            api_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            ridx_reg      <= 8'd0;
            end_reg       <= 8'd0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hunting_reg   <= hunting_next;
            count_reg     <= count_next;
            length_reg    <= length_next;
            api_reg       <= api_next;
            sum_reg       <= sum_next;
            ridx_reg      <= ridx_next;
            end_reg       <= end_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result fields while the output stalls
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            rvalid_reg <= rvalid_next;
            avail_reg  <= avail_next;
            status_reg <= status_next;
        end
    end

    // Payload store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            payload_mem[mem_waddr] <= b;
        if (mem_re)
            rd_data_reg <= payload_mem[ridx_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = rvalid_reg;
    assign m_axis_tdata  = {5'd0, status_reg, avail_reg, (rvalid_reg ? rd_data_reg : 8'd0)};

`ifndef SYNTHESIS
    a_ready_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (ridx_reg != end_reg))
        else $error("payload marked ready with nothing left to read");
    a_status_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != api_fd_pkg::STAT_NONE) |-> !rvalid_reg)
        else $error("frame status reported alongside a popped byte");
    a_accept_ends_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && status_next == api_fd_pkg::STAT_ACCEPT) |=> (hunting_reg && ready_reg))
        else $error("accepted frame did not publish payload");
    a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && hunting_reg && head.item.delim) |=> (!ready_reg && count_reg == 9'd1))
        else $error("delimiter did not restart collection");
`endif

endmodule

@@ rtl/api_frame_deframer_unit.sv @@
// API frame deframer.
// Input transfers on s_axis: tuser selects the operation (0 push a received
// serial byte carried in tdata, 1 pop one stored payload byte). Each input
// transfer yields exactly one output transfer on m_axis: tuser is read_valid,
// tdata carries read_byte, bytes_available and frame_status.
// Pushed bytes are parsed as delimiter-led frames with a length, an API id,
// four header bytes, payload and checksum; an accepted frame makes its
// payload readable through pops. A new delimiter discards unread payload.
// The APB port holds expected_api_id at address 0; write it only while idle.
// Throughput: one transfer per cycle in each direction while m_axis is not
// stalled, set by the frame update in the back end and the one-write,
// one-read payload store. Each input item is held in the two-entry input
// queue, and its result is then held in the output register until m_axis
// takes it.
// Reset clears the queue and output register and starts hunting for a
// delimiter; payload store contents are not cleared.
// When m_axis stalls, the output register holds its result, the queue fills
// and s_axis_tready drops once two items wait.
module api_frame_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] read_byte, [15:8] bytes_available,
                                        // [18:16] frame_status, [23:19] zero
    output logic        m_axis_tuser,   // [0] read_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    api_fd_pkg::head_t head;
    logic              head_take;
    logic [7:0]        api_id_reg, api_id_next;
    logic              reg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == api_fd_pkg::REG_API_ID);

    always_comb
    begin
        api_id_next = reg_wr ? pwdata[7:0] : api_id_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            api_id_reg <= api_fd_pkg::API_ID_RESET;
        else
            api_id_reg <= api_id_next;
    end

    assign prdata = (paddr[2] == api_fd_pkg::REG_API_ID) ? {24'd0, api_id_reg} : 32'd0;

    api_fd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .head_take     (head_take)
    );

    api_fd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .head_take       (head_take),
        .expected_api_id (api_id_reg),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser)
    );

endmodule

@@ dv/tb.sv @@
module tb;

    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PHASE_ITEMS     = 45;

    // One output transfer as the block should present it
    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic [7:0] bytes_available;
        logic [2:0] frame_status;
    } deframe_out_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_WRONG_ID,
        FR_OVERLONG,
        FR_SHORT_LEN,
        FR_CUT
    } frame_kind_t;

    // Tracks the frame parser and the payload read port, and checks the output stream
    class frame_tracker;
        logic [7:0]   api_id;
        logic [7:0]   payload_mem [api_fd_pkg::STORE_DEPTH];
        bit           seeking;
        logic [8:0]   frame_pos;
        logic [7:0]   len_lo;
        logic [7:0]   frame_api;
        logic [7:0]   sum_acc;
        logic [7:0]   pop_ptr;
        logic [7:0]   pop_end;
        bit           pop_live;
        deframe_out_t pending_results [$];
        int           errors;

        function new();
            api_id    = api_fd_pkg::API_ID_RESET;
            seeking   = 1'b1;
            frame_pos = '0;
            len_lo    = '0;
            frame_api = '0;
            sum_acc   = '0;
            pop_ptr   = '0;
            pop_end   = '0;
            pop_live  = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
            errors++;
        endtask

        // Advance the parser by one transfer and queue the result it causes
        function void absorb_item(logic op, logic [7:0] data);
            deframe_out_t res;
            logic [8:0]   pos;
            logic [8:0]   next_pos;
            logic [8:0]   body;
            logic [7:0]   idx;
            res = '0;
            if (op == api_fd_pkg::OP_POP)
            begin
                if (pop_live)
                begin
                    res.read_byte  = payload_mem[pop_ptr];
                    res.read_valid = 1'b1;
                    pop_ptr        = pop_ptr + 8'd1;
                    if (pop_ptr == pop_end)
                    begin
                        pop_live = 1'b0;
                        pop_ptr  = '0;
                    end
                end
            end
            else if (seeking)
            begin
                // A delimiter opens a frame and throws away unread payload
                if (data == api_fd_pkg::DELIM)
                begin
                    seeking   = 1'b0;
                    frame_pos = 9'd1;
                    sum_acc   = '0;
                    pop_ptr   = '0;
                    pop_end   = '0;
                    pop_live  = 1'b0;
                end
            end
            else
            begin
                pos = frame_pos;
                if (pos == api_fd_pkg::LEN_POS)
                    len_lo = data;
                if (pos == api_fd_pkg::API_POS)
                    frame_api = data;
                if (pos >= api_fd_pkg::API_POS)
                    sum_acc = sum_acc + data;
                if (pos >= api_fd_pkg::PAYLOAD_START)
                begin
                    idx = 8'(pos - api_fd_pkg::PAYLOAD_START);
                    payload_mem[idx] = data;
                end
                next_pos  = pos + 9'd1;
                frame_pos = next_pos;
                if (next_pos >= api_fd_pkg::MIN_FRAME)
                begin
                    body = next_pos - api_fd_pkg::BODY_OVERHEAD;
                    if (body > {1'b0, len_lo})
                    begin
                        seeking = 1'b1;
                        res.frame_status = api_fd_pkg::STAT_OVERLONG;
                    end
                    else if (body == {1'b0, len_lo})
                    begin
                        if (sum_acc != api_fd_pkg::SUM_GOOD)
                            res.frame_status = api_fd_pkg::STAT_BAD_SUM;
                        else if (frame_api != api_id)
                            res.frame_status = api_fd_pkg::STAT_WRONG_ID;
                        else
                        begin
                            seeking  = 1'b1;
                            pop_end  = 8'(next_pos - api_fd_pkg::PAYLOAD_OFFSET);
                            pop_ptr  = '0;
                            pop_live = 1'b1;
                            res.frame_status = api_fd_pkg::STAT_ACCEPT;
                        end
                    end
                end
            end
            res.bytes_available = pop_live ? pop_end - pop_ptr : 8'd0;
            pending_results.push_back(res);
        endfunction

        // Compare one output transfer with the oldest queued result
        task match_output(logic [23:0] data, logic user);
            deframe_out_t want;
            if (pending_results.size() == 0)
            begin
                report("output transfer with no result pending", data, 0);
                return;
            end
            want = pending_results.pop_front();
            if (data[7:0] !== want.read_byte)
                report("read_byte", data[7:0], want.read_byte);
            if (user !== want.read_valid)
                report("read_valid", user, want.read_valid);
            if (data[15:8] !== want.bytes_available)
                report("bytes_available", data[15:8], want.bytes_available);
            if (data[18:16] !== want.frame_status)
                report("frame_status", data[18:16], want.frame_status);
            if (data[23:19] !== 5'd0)
                report("tdata padding", data[23:19], 0);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_tracker sb;
    int           idle_pct;
    int           stall_pct;
    bit           hold_off_req;
    int           items_sent;
    int           quiet_cycles;
    logic [7:0]   frame_bytes [$];

    api_frame_deframer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sample both streams at the rising edge; outputs first, then the new input
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.match_output(m_axis_tdata, m_axis_tuser);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.absorb_item(s_axis_tuser, s_axis_tdata);
        if (rst_n && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Stop a hung run
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one transfer after random idle cycles; return at the falling edge after it is taken
    task automatic send_item(logic op, logic [7:0] data);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push_frame_bytes();
        foreach (frame_bytes[i])
            send_item(api_fd_pkg::OP_PUSH, frame_bytes[i]);
    endtask

    // Hold the sender until every result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Write expected_api_id, then read it back
    task automatic write_api_id(logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {api_fd_pkg::REG_API_ID, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.api_id = val;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== val)
            sb.report("expected_api_id readback", prdata, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pops(int count);
        repeat (count)
            send_item(api_fd_pkg::OP_POP, 8'($urandom_range(255)));
    endtask

    task automatic send_noise(int count);
        repeat (count)
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // Build a frame of the given kind, push it, then read some of its payload
    task automatic send_frame(frame_kind_t kind, int pay_len);
        logic [7:0] len_byte;
        logic [7:0] api;
        logic [7:0] sum;
        logic [7:0] data;
        int         pops;
        if (kind == FR_SHORT_LEN)
            pay_len = 1;
        len_byte = 8'(pay_len + 5);
        if (kind == FR_SHORT_LEN)
            len_byte = 8'($urandom_range(5));
        if (kind == FR_OVERLONG)
            len_byte = 8'(pay_len + 4);
        api = sb.api_id;
        if (kind == FR_WRONG_ID)
            api = api ^ 8'($urandom_range(1, 255));
        frame_bytes = '{api_fd_pkg::DELIM, 8'($urandom_range(255)), len_byte, api};
        sum = api;
        repeat (4 + pay_len)
        begin
            // Drop an occasional delimiter inside the frame body
            data = ($urandom_range(15) == 0) ? api_fd_pkg::DELIM : 8'($urandom_range(255));
            frame_bytes.push_back(data);
            sum = sum + data;
        end
        sum = ~sum;
        if (kind == FR_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        if (kind == FR_CUT)
            frame_bytes = frame_bytes[0:$urandom_range(2, frame_bytes.size() - 2)];
        push_frame_bytes();
        // Flush a frame that failed its checks
        if (kind == FR_BAD_SUM || kind == FR_WRONG_ID)
            send_item(api_fd_pkg::OP_PUSH, 8'($urandom_range(255)));
        if (pay_len <= 16)
            pops = ($urandom_range(1) == 1) ? pay_len + $urandom_range(2)
                                             : $urandom_range(pay_len + 2);
        else
            pops = $urandom_range(24);
        send_pops(pops);
    endtask

    // Mostly well-formed frames, with broken frames, stray pops and noise mixed in
    task automatic run_traffic(int budget);
        int          start;
        int          pick;
        int          len_pick;
        int          pay_len;
        frame_kind_t kind;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                len_pick = $urandom_range(99);
                if (len_pick < 85)
                    pay_len = $urandom_range(1, 16);
                else if (len_pick < 97)
                    pay_len = $urandom_range(17, 64);
                else
                    pay_len = $urandom_range(65, 250);
                pick = $urandom_range(99);
                if (pick < 55)
                    kind = FR_GOOD;
                else if (pick < 65)
                    kind = FR_BAD_SUM;
                else if (pick < 75)
                    kind = FR_WRONG_ID;
                else if (pick < 85)
                    kind = FR_OVERLONG;
                else if (pick < 93)
                    kind = FR_SHORT_LEN;
                else
                    kind = FR_CUT;
                send_frame(kind, pay_len);
            end
            else if (pick < 86)
                send_pops($urandom_range(1, 6));
            else
                send_noise($urandom_range(1, 4));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = api_fd_pkg::OP_PUSH;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_off_req  = 1'b0;
        items_sent    = 0;
        quiet_cycles  = 0;
        sb            = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: pop with nothing stored
        send_item(api_fd_pkg::OP_POP, 8'hFF);
        // Shortest good frame, delimiter and extremes among the header bytes
        frame_bytes = '{8'h7E, 8'hFF, 8'h06, 8'h81, 8'h00, 8'h7E, 8'hFF, 8'h5A, 8'h00, 8'hA7};
        push_frame_bytes();
        // Read the one payload byte, then pop past the end
        send_item(api_fd_pkg::OP_POP, 8'h00);
        send_item(api_fd_pkg::OP_POP, 8'h00);
        // Declared length too short: dropped as overlong at the tenth byte
        frame_bytes = '{8'h7E, 8'h00, 8'h03, 8'h81, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
        push_frame_bytes();

        // Random phases, each with its own API id and its own mix of idle and stall rates
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    write_api_id(8'h00);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    write_api_id(8'hFF);
                    idle_pct  = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    write_api_id(8'($urandom_range(255)));
                    idle_pct  = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    write_api_id(api_fd_pkg::API_ID_RESET);
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            run_traffic(PHASE_ITEMS);
            if (ph == 0)
            begin
                // Stall the output while a maximum-size frame keeps coming
                hold_off_req = 1'b1;
                send_frame(FR_GOOD, 250);
            end
            if (ph == 2)
                wait_idle();
            run_traffic(PHASE_ITEMS);
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (sb.pending() != 0)
            sb.report("results never delivered", sb.pending(), 0);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
